>>> sv/i2cee_pkg.sv
// Shared types and constants of the I2C EEPROM pointer unit.
package i2cee_pkg;

   // Bus byte and pointer widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned PTR_W  = 16;

   // Modulo reduction of a pointer by the depth: a reciprocal estimate of the quotient,
   // then one correcting subtract. The depth is at least 2**BYTE_W, so the reciprocal
   // 2**RECIP_SHIFT / DEPTH fits in RECIP_W bits, the quotient of a PTR_W-bit value fits
   // in BYTE_W bits and the estimate falls short by at most one.
   localparam int unsigned REDUCE_STEPS = 2;
   localparam int unsigned STEP_W       = $clog2(REDUCE_STEPS);
   localparam int unsigned RECIP_SHIFT  = PTR_W + BYTE_W;
   localparam int unsigned RECIP_W      = PTR_W + 1;
   localparam int unsigned QPROD_W      = RECIP_SHIFT + BYTE_W;
   localparam int unsigned BPROD_W      = BYTE_W + RECIP_W;

   // Bus event codes carried by one request word
   typedef enum logic [1:0] {
      ACT_MATCH_WR = 2'd0,
      ACT_MATCH_RD = 2'd1,
      ACT_WRITE    = 2'd2,
      ACT_READ     = 2'd3
   } action_type;

   // Pointer load phase
   typedef enum logic [1:0] {
      PH_DATA = 2'd0,
      PH_LO   = 2'd1,
      PH_HI   = 2'd2
   } phase_type;

endpackage

>>> sv/i2cee_if.sv
// Valid/ready channel interfaces for request and response words.
interface i2cee_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [i2cee_pkg::BYTE_W-1:0]  write_data;

   modport source (output valid, output action, output write_data, input ready);
   modport sink   (input valid, input action, input write_data, output ready);
endinterface

interface i2cee_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [i2cee_pkg::BYTE_W-1:0]  read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

>>> sv/i2cee_store.sv
// Byte store: synchronous RAM with one write and one read port, with a zeroing sweep after reset.
module i2cee_store #(
   parameter int unsigned DEPTH = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [i2cee_pkg::BYTE_W-1:0]     wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [i2cee_pkg::BYTE_W-1:0]     rd_data,
   output logic                             clr_busy
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic [i2cee_pkg::BYTE_W-1:0] store_ff [DEPTH];
   logic [i2cee_pkg::BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]                clr_ff;
   logic [AW-1:0]                clr_in;
   logic                         busy_ff;
   logic                         busy_in;
   logic                         we;
   logic [AW-1:0]                waddr;
   logic [i2cee_pkg::BYTE_W-1:0] wdata;

   // Advance the clearing sweep, drop busy on the last entry
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // Sweep owns the write port while clearing
   assign we    = busy_ff | wr_en;
   assign waddr = busy_ff ? clr_ff : wr_addr;
   assign wdata = busy_ff ? '0 : wr_data;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = busy_ff;

endmodule

>>> sv/i2c_eeprom_slave_pointer_unit.sv
// Top level of the I2C EEPROM target: pointer load, auto-increment and byte store.
// Each request word is one bus event: a match in either direction, a byte written by
// the master or a byte read by the master. Matches and data writes complete in the idle
// state. A read waits in ST_READ on the registered read data of the store and on the
// response register, until it is free. Each of the two pointer bytes passes through
// ST_REDUCE, forming the address modulo DEPTH (after the low byte also the pointer)
// from a reciprocal estimate of the quotient and one correcting subtract.
// After reset the store is swept to zero, one entry per cycle; no request is taken
// until the sweep ends. The response channel carries one word per read.
module i2c_eeprom_slave_pointer_unit #(
   parameter int unsigned DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   i2cee_req_if.sink         req_chan,
   i2cee_rsp_if.source       rsp_chan
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam logic [i2cee_pkg::RECIP_W-1:0] DEPTH_V = i2cee_pkg::RECIP_W'(DEPTH);
   localparam logic [i2cee_pkg::RECIP_W-1:0] RECIP   =
      i2cee_pkg::RECIP_W'((64'd1 << i2cee_pkg::RECIP_SHIFT) / DEPTH);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_REDUCE
   } state_type;

   state_type                          state_ff, state_in;
   i2cee_pkg::phase_type               phase_ff, phase_in;
   logic [i2cee_pkg::PTR_W-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]                      addr_ff, addr_in;
   logic [i2cee_pkg::PTR_W-1:0]        rem_ff, rem_in;
   logic [i2cee_pkg::BYTE_W-1:0]       quot_ff, quot_in;
   logic [i2cee_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                               keep_ff, keep_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [i2cee_pkg::BYTE_W-1:0]       rsp_data_ff, rsp_data_in;

   logic                               req_fire;
   logic [AW-1:0]                      addr_next;
   logic [i2cee_pkg::QPROD_W-1:0]      quot_prod;
   logic [i2cee_pkg::BPROD_W-1:0]      back_prod;
   logic [i2cee_pkg::PTR_W-1:0]        rem_raw;
   logic                               rem_over;
   logic [i2cee_pkg::PTR_W-1:0]        rem_next;
   logic                               mem_we;
   logic                               mem_re;
   logic [i2cee_pkg::BYTE_W-1:0]       mem_rd_data;
   logic                               clr_busy;

   i2cee_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mem_we),
      .wr_addr  (addr_ff),
      .wr_data  (req_chan.write_data),
      .rd_en    (mem_re),
      .rd_addr  (addr_ff),
      .rd_data  (mem_rd_data),
      .clr_busy (clr_busy)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;

   // Wrap the address on increment
   assign addr_next = (addr_ff == AW'(DEPTH - 1)) ? '0 : addr_ff + 1'b1;

   // Estimate the quotient by the reciprocal, at most one short
   assign quot_prod = i2cee_pkg::QPROD_W'(rem_ff) * i2cee_pkg::QPROD_W'(RECIP);

   // Form the remainder from the held quotient, then correct it once
   assign back_prod = i2cee_pkg::BPROD_W'(quot_ff) * i2cee_pkg::BPROD_W'(DEPTH_V);
   assign rem_raw   = rem_ff - back_prod[i2cee_pkg::PTR_W-1:0];
   assign rem_over  = {1'b0, rem_raw} >= DEPTH_V;
   assign rem_next  = rem_over ? rem_raw - DEPTH_V[i2cee_pkg::PTR_W-1:0] : rem_raw;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      ptr_in       = ptr_ff;
      addr_in      = addr_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      keep_in      = keep_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      // Drop the response word once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            if (!clr_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (i2cee_pkg::action_type'(req_chan.action))
                  i2cee_pkg::ACT_MATCH_WR: begin
                     phase_in = i2cee_pkg::PH_HI;
                  end
                  i2cee_pkg::ACT_MATCH_RD: begin
                  end
                  i2cee_pkg::ACT_WRITE: begin
                     case (phase_ff)
                        i2cee_pkg::PH_HI: begin
                           // High byte: raw pointer kept, address reduced
                           ptr_in   = {req_chan.write_data, {i2cee_pkg::BYTE_W{1'b0}}};
                           rem_in   = {req_chan.write_data, {i2cee_pkg::BYTE_W{1'b0}}};
                           keep_in  = 1'b0;
                           step_in  = i2cee_pkg::STEP_W'(i2cee_pkg::REDUCE_STEPS - 1);
                           phase_in = i2cee_pkg::PH_LO;
                           state_in = ST_REDUCE;
                        end
                        i2cee_pkg::PH_LO: begin
                           // Low byte: OR in, pointer itself reduced afterwards
                           ptr_in   = ptr_ff | {{i2cee_pkg::BYTE_W{1'b0}}, req_chan.write_data};
                           rem_in   = ptr_ff | {{i2cee_pkg::BYTE_W{1'b0}}, req_chan.write_data};
                           keep_in  = 1'b1;
                           step_in  = i2cee_pkg::STEP_W'(i2cee_pkg::REDUCE_STEPS - 1);
                           phase_in = i2cee_pkg::PH_DATA;
                           state_in = ST_REDUCE;
                        end
                        default: begin
                           // Data byte: store and advance
                           mem_we  = 1'b1;
                           addr_in = addr_next;
                           ptr_in  = i2cee_pkg::PTR_W'(addr_next);
                        end
                     endcase
                  end
                  i2cee_pkg::ACT_READ: begin
                     mem_re   = 1'b1;
                     addr_in  = addr_next;
                     ptr_in   = i2cee_pkg::PTR_W'(addr_next);
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // Hold the read byte until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_data_in  = mem_rd_data;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REDUCE: begin
            // Latch the quotient estimate first, then take the remainder
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               addr_in = rem_next[AW-1:0];
               if (keep_ff) begin
                  ptr_in = rem_next;
               end
               state_in = ST_IDLE;
            end else begin
               quot_in = quot_prod[i2cee_pkg::RECIP_SHIFT +: i2cee_pkg::BYTE_W];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= i2cee_pkg::PH_DATA;
         ptr_ff       <= '0;
         addr_ff      <= '0;
         step_ff      <= '0;
         keep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ptr_ff       <= ptr_in;
         addr_ff      <= addr_in;
         step_ff      <= step_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;

   // No request while the store is swept
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_chan.ready)
      else $error("request taken during clearing sweep");

   // Wrapped address always inside the store
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      32'(addr_ff) < DEPTH)
      else $error("address beyond store depth");

   // A read moves to the wait for store data
   a_read_wait: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.action == i2cee_pkg::ACT_READ) |=> (state_ff == ST_READ))
      else $error("read not waiting on store");

   // A read byte lands in the response register once it is free
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && (!rsp_valid_ff || rsp_chan.ready)) |=> rsp_valid_ff)
      else $error("read byte not presented");

endmodule
